/* rtl/sph_poly6_kernel_eval_core_assert.svh */
// ----------------------------------------------------------------------------
// poly6 kernel core assertion macros
// implication checks on the core clock, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef SPH_POLY6_KERNEL_EVAL_CORE_ASSERT_SVH
`define SPH_POLY6_KERNEL_EVAL_CORE_ASSERT_SVH

// same-cycle implication
`define SPH_P6_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sph_p6 same-cycle check failed");

// next-cycle implication
`define SPH_P6_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sph_p6 next-cycle check failed");

`endif

/* rtl/sph_p6_pkg.sv */
// ----------------------------------------------------------------------------
// sph_p6_pkg
// shared widths, register indexes and coefficient helpers of the poly6 core
// ----------------------------------------------------------------------------
package sph_p6_pkg;

    localparam int LIMB_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int RADIUS_WIDTH    = 32;
    localparam int COEFF_WIDTH     = 32;
    localparam int SHIFT_WIDTH     = 6;
    // |3d - 4 r2| with d and r2 both below 2^32
    localparam int DIFF_WIDTH      = RADIUS_WIDTH + 2;

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_SQ_RESET = 32'h0100_0000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_RADIUS_SQ    = 8'd0,
        CFG_VALUE_COEFF  = 8'd1,
        CFG_DERIV_COEFF  = 8'd2,
        CFG_RESULT_SHIFT = 8'd3
    } cfg_index_t;

    // coefficient kept as sign and magnitude
    typedef struct packed {
        logic                   neg;
        logic [COEFF_WIDTH-1:0] mag;
    } coeff_t;

    function automatic coeff_t coeff_of(input logic [COEFF_WIDTH-1:0] v);
        coeff_t c;
        c.neg = v[COEFF_WIDTH-1];
        c.mag = v[COEFF_WIDTH-1] ? (~v + COEFF_WIDTH'(1)) : v;
        return c;
    endfunction

endpackage

/* rtl/sph_p6_wmul.sv */
// ----------------------------------------------------------------------------
// sph_p6_wmul
// two-stage unsigned wide multiplier: 32-bit limb partial products, then
// one add of the even and odd partial rows
// ----------------------------------------------------------------------------
module sph_p6_wmul #(
    parameter int A_WIDTH = 64,
    parameter int B_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic [1:0]                 stage_en,
    input  logic [A_WIDTH-1:0]         a,
    input  logic [B_WIDTH-1:0]         b,
    output logic [A_WIDTH+B_WIDTH-1:0] p
);

    localparam int LW         = sph_p6_pkg::LIMB_WIDTH;
    localparam int NUM_LIMBS  = (A_WIDTH + LW - 1) / LW;
    localparam int PART_WIDTH = LW + B_WIDTH;
    localparam int SUM_WIDTH  = (NUM_LIMBS + 1) * LW;
    localparam int P_WIDTH    = A_WIDTH + B_WIDTH;

    logic [NUM_LIMBS*LW-1:0] a_ext;
    logic [PART_WIDTH-1:0]   part_next [NUM_LIMBS];
    logic [PART_WIDTH-1:0]   part_reg  [NUM_LIMBS];
    logic [SUM_WIDTH-1:0]    even_row;
    logic [SUM_WIDTH-1:0]    odd_row;
    logic [SUM_WIDTH-1:0]    sum_next;
    logic [P_WIDTH-1:0]      p_reg;

    assign a_ext = (NUM_LIMBS*LW)'(a);

    always_comb begin
        for (int c = 0; c < NUM_LIMBS; c++) begin
            part_next[c] = PART_WIDTH'(a_ext[c*LW +: LW]) * PART_WIDTH'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            for (int c = 0; c < NUM_LIMBS; c++) begin
                part_reg[c] <= part_next[c];
            end
        end
    end

    // partials two limbs apart never overlap, so each row is a plain placement
    always_comb begin
        even_row = '0;
        odd_row  = '0;
        for (int c = 0; c < NUM_LIMBS; c++) begin
            if (c[0] == 1'b0) begin
                even_row[c*LW +: PART_WIDTH] = part_reg[c];
            end else begin
                odd_row[c*LW +: PART_WIDTH] = part_reg[c];
            end
        end
        sum_next = even_row + odd_row;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            p_reg <= sum_next[P_WIDTH-1:0];
        end
    end

    assign p = p_reg;

endmodule

/* rtl/sph_p6_finish.sv */
// ----------------------------------------------------------------------------
// sph_p6_finish
// three-stage result tail: apply sign, arithmetic right shift (floor),
// saturate to the result width and zero out-of-range words
// ----------------------------------------------------------------------------
module sph_p6_finish #(
    parameter int MAG_WIDTH    = 128,
    parameter int RESULT_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic [2:0]                         stage_en,
    input  logic [MAG_WIDTH-1:0]               mag,
    input  logic                               neg,
    input  logic                               live,
    input  logic [sph_p6_pkg::SHIFT_WIDTH-1:0] shift,
    output logic [RESULT_WIDTH-1:0]            result
);

    localparam int SW = MAG_WIDTH + 1;

    logic [SW-1:0]           mag_ext;
    logic signed [SW-1:0]    signed_reg;
    logic signed [SW-1:0]    shifted_reg;
    logic                    live_a_reg;
    logic                    live_b_reg;
    logic [SW-RESULT_WIDTH:0] top_bits;
    logic                    fits;
    logic [RESULT_WIDTH-1:0] sat_value;
    logic [RESULT_WIDTH-1:0] result_next;
    logic [RESULT_WIDTH-1:0] result_reg;

    assign mag_ext = {1'b0, mag};

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            signed_reg <= $signed(neg ? (~mag_ext + SW'(1)) : mag_ext);
            live_a_reg <= live;
        end
        if (stage_en[1]) begin
            shifted_reg <= signed_reg >>> shift;
            live_b_reg  <= live_a_reg;
        end
        if (stage_en[2]) begin
            result_reg <= result_next;
        end
    end

    // fits when every bit above the result sign matches it
    always_comb begin
        top_bits = shifted_reg[SW-1:RESULT_WIDTH-1];
        fits     = (top_bits == '0) || (top_bits == '1);
        if (fits) begin
            sat_value = shifted_reg[RESULT_WIDTH-1:0];
        end else if (shifted_reg[SW-1]) begin
            sat_value = {1'b1, {(RESULT_WIDTH-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
        end
        result_next = live_b_reg ? sat_value : '0;
    end

    assign result = result_reg;

endmodule

/* rtl/sph_poly6_kernel_eval_core.sv */
// ----------------------------------------------------------------------------
// sph_poly6_kernel_eval_core
// Poly6 SPH kernel: value, gradient and laplacian for one displacement word.
// s_tdata carries dx, dy, dz; m_tdata carries kernel_value, grad_x/y/z and
// lap_value, m_tuser flags in_range (all results zero when r2 >= radius_sq).
// The cfg channel writes radius_sq, value_coeff, deriv_coeff, result_shift;
// it is always ready and must only be used while no word is in flight.
// One word is taken every cycle while s_tready is high: a 14-stage
// pipeline whose deepest steps are chained 32-bit limb multipliers (d^2,
// then d^3 or d^2*coord, then the coefficient), each split over two stages.
// When m_tready is low the pipeline compacts into its empty stages and
// s_tready drops only once every stage holds a word; nothing is lost or
// repeated. Reset (aresetn low, synchronous) empties the pipeline and loads
// radius_sq = 1.0 in Q8.24 and zero for the other registers.
// ----------------------------------------------------------------------------
`include "sph_poly6_kernel_eval_core_assert.svh"

module sph_poly6_kernel_eval_core #(
    parameter int COORD_WIDTH  = 16,
    parameter int RESULT_WIDTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // input words
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,   // dx, dy, dz
    // result words
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [((5*RESULT_WIDTH+7)/8)*8-1:0]        m_tdata,   // kernel_value, grad_x,
                                                                   // grad_y, grad_z, lap_value
    output logic                                       m_tuser,   // in_range
    // register writes
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [sph_p6_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [sph_p6_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

    localparam int NUM_STAGES = 14;
    localparam int RADW       = sph_p6_pkg::RADIUS_WIDTH;
    localparam int COEFW      = sph_p6_pkg::COEFF_WIDTH;
    localparam int DIFFW      = sph_p6_pkg::DIFF_WIDTH;
    localparam int R2W        = 2 * COORD_WIDTH;
    localparam int CMP_WIDTH  = (R2W > RADW) ? R2W : RADW;
    localparam int DD_WIDTH   = 2 * RADW;
    localparam int DT_WIDTH   = DIFFW + RADW;
    localparam int D3_WIDTH   = 3 * RADW;
    localparam int G_WIDTH    = DD_WIDTH + COORD_WIDTH;
    localparam int KV_WIDTH   = D3_WIDTH + COEFW;
    localparam int GR_WIDTH   = G_WIDTH + COEFW;
    localparam int LP_WIDTH   = DT_WIDTH + COEFW;

    typedef struct packed {
        logic                        in_range;
        logic                        lap_neg;
        logic [2:0]                  axis_neg;
        logic [RADW-1:0]             d;
        logic [2:0][COORD_WIDTH-1:0] mag;
    } carry_t;

    function automatic logic [COORD_WIDTH-1:0] coord_mag(input logic [COORD_WIDTH-1:0] v);
        return v[COORD_WIDTH-1] ? (~v + COORD_WIDTH'(1)) : v;
    endfunction

    // ------------------------------------------------------------------ config
    logic [RADW-1:0]                      radius_sq_reg;
    sph_p6_pkg::coeff_t                   value_coeff_reg;
    sph_p6_pkg::coeff_t                   deriv_coeff_reg;
    logic [sph_p6_pkg::SHIFT_WIDTH-1:0]   result_shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_sq_reg    <= sph_p6_pkg::RADIUS_SQ_RESET;
            value_coeff_reg  <= '0;
            deriv_coeff_reg  <= '0;
            result_shift_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sph_p6_pkg::CFG_RADIUS_SQ: begin
                    radius_sq_reg <= cfg_data[RADW-1:0];
                end
                sph_p6_pkg::CFG_VALUE_COEFF: begin
                    value_coeff_reg <= sph_p6_pkg::coeff_of(cfg_data[COEFW-1:0]);
                end
                sph_p6_pkg::CFG_DERIV_COEFF: begin
                    deriv_coeff_reg <= sph_p6_pkg::coeff_of(cfg_data[COEFW-1:0]);
                end
                sph_p6_pkg::CFG_RESULT_SHIFT: begin
                    result_shift_reg <= cfg_data[sph_p6_pkg::SHIFT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------- pipeline flow
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] valid_next;
    logic [NUM_STAGES:1] all_full;
    logic [NUM_STAGES:1] adv;
    logic [NUM_STAGES:1] shift_in;

    // a stage moves when the output is ready or it or some later stage is empty
    for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_full
        assign all_full[k] = &valid_reg[NUM_STAGES:k];
    end

    assign adv        = {NUM_STAGES{m_tready}} | ~all_full;
    assign shift_in   = {valid_reg[NUM_STAGES-1:1], s_tvalid};
    assign valid_next = (adv & shift_in) | (~adv & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = valid_reg[NUM_STAGES];

    // ------------------------------------------- stages 1..5: r2, d, |3d-4r2|
    logic [COORD_WIDTH-1:0] s1_mag_reg [3];
    logic [2:0]             s1_neg_reg;
    logic [R2W-1:0]         s2_sq_reg  [3];
    logic [COORD_WIDTH-1:0] s2_mag_reg [3];
    logic [2:0]             s2_neg_reg;
    logic [R2W-1:0]         s3_r2_reg;
    logic [COORD_WIDTH-1:0] s3_mag_reg [3];
    logic [2:0]             s3_neg_reg;
    logic [RADW-1:0]        s4_d_reg;
    logic [RADW-1:0]        s4_r2_reg;
    logic                   s4_in_range_reg;
    logic [COORD_WIDTH-1:0] s4_mag_reg [3];
    logic [2:0]             s4_neg_reg;
    logic [DIFFW-1:0]       s5_t_reg;

    logic [CMP_WIDTH-1:0]   r2_wide;
    logic [CMP_WIDTH-1:0]   radius_wide;
    logic [DIFFW-1:0]       three_d;
    logic [DIFFW-1:0]       four_r2;
    logic                   lap_neg_next;
    logic [DIFFW-1:0]       t_next;
    carry_t                 carry_next;
    carry_t                 carry_reg [5:11];

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int i = 0; i < 3; i++) begin
                s1_mag_reg[i] <= coord_mag(s_tdata[i*COORD_WIDTH +: COORD_WIDTH]);
                s1_neg_reg[i] <= s_tdata[i*COORD_WIDTH + COORD_WIDTH - 1];
            end
        end
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                s2_sq_reg[i]  <= R2W'(s1_mag_reg[i]) * R2W'(s1_mag_reg[i]);
                s2_mag_reg[i] <= s1_mag_reg[i];
            end
            s2_neg_reg <= s1_neg_reg;
        end
        if (adv[3]) begin
            // three squares of at most 2^(2w-2) never carry out of 2w bits
            s3_r2_reg  <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
            s3_mag_reg <= s2_mag_reg;
            s3_neg_reg <= s2_neg_reg;
        end
        if (adv[4]) begin
            s4_in_range_reg <= r2_wide < radius_wide;
            s4_d_reg        <= radius_sq_reg - r2_wide[RADW-1:0];
            s4_r2_reg       <= r2_wide[RADW-1:0];
            s4_mag_reg      <= s3_mag_reg;
            s4_neg_reg      <= s3_neg_reg;
        end
        if (adv[5]) begin
            s5_t_reg     <= t_next;
            carry_reg[5] <= carry_next;
        end
        for (int k = 6; k <= 11; k++) begin
            if (adv[k]) begin
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    assign r2_wide     = CMP_WIDTH'(s3_r2_reg);
    assign radius_wide = CMP_WIDTH'(radius_sq_reg);

    always_comb begin
        three_d      = {2'b00, s4_d_reg} + {1'b0, s4_d_reg, 1'b0};
        four_r2      = {s4_r2_reg, 2'b00};
        lap_neg_next = four_r2 > three_d;
        t_next       = lap_neg_next ? (four_r2 - three_d) : (three_d - four_r2);

        carry_next.in_range = s4_in_range_reg;
        carry_next.lap_neg  = lap_neg_next;
        carry_next.axis_neg = s4_neg_reg;
        carry_next.d        = s4_d_reg;
        for (int i = 0; i < 3; i++) begin
            carry_next.mag[i] = s4_mag_reg[i];
        end
    end

    // ------------------------------------ stages 6..7: d^2 and d*|3d-4r2|
    logic [DD_WIDTH-1:0] dd_prod;
    logic [DT_WIDTH-1:0] dt_prod;
    logic [DT_WIDTH-1:0] dt8_reg;
    logic [DT_WIDTH-1:0] dt9_reg;

    sph_p6_wmul #(.A_WIDTH(RADW), .B_WIDTH(RADW)) u_mul_dd (
        .aclk     (aclk),
        .stage_en (adv[7:6]),
        .a        (carry_reg[5].d),
        .b        (carry_reg[5].d),
        .p        (dd_prod)
    );

    sph_p6_wmul #(.A_WIDTH(DIFFW), .B_WIDTH(RADW)) u_mul_dt (
        .aclk     (aclk),
        .stage_en (adv[7:6]),
        .a        (s5_t_reg),
        .b        (carry_reg[5].d),
        .p        (dt_prod)
    );

    // ------------------------------------ stages 8..9: d^3 and d^2 * |coord|
    logic [D3_WIDTH-1:0] d3_prod;
    logic [G_WIDTH-1:0]  g_prod [3];

    sph_p6_wmul #(.A_WIDTH(DD_WIDTH), .B_WIDTH(RADW)) u_mul_d3 (
        .aclk     (aclk),
        .stage_en (adv[9:8]),
        .a        (dd_prod),
        .b        (carry_reg[7].d),
        .p        (d3_prod)
    );

    for (genvar i = 0; i < 3; i++) begin : g_grad_mul
        sph_p6_wmul #(.A_WIDTH(DD_WIDTH), .B_WIDTH(COORD_WIDTH)) u_mul_g (
            .aclk     (aclk),
            .stage_en (adv[9:8]),
            .a        (dd_prod),
            .b        (carry_reg[7].mag[i]),
            .p        (g_prod[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv[8]) begin
            dt8_reg <= dt_prod;
        end
        if (adv[9]) begin
            dt9_reg <= dt8_reg;
        end
    end

    // --------------------------------------- stages 10..11: coefficient
    logic [KV_WIDTH-1:0] kv_prod;
    logic [GR_WIDTH-1:0] gr_prod [3];
    logic [LP_WIDTH-1:0] lp_prod;

    sph_p6_wmul #(.A_WIDTH(D3_WIDTH), .B_WIDTH(COEFW)) u_mul_kv (
        .aclk     (aclk),
        .stage_en (adv[11:10]),
        .a        (d3_prod),
        .b        (value_coeff_reg.mag),
        .p        (kv_prod)
    );

    for (genvar i = 0; i < 3; i++) begin : g_grad_coef
        sph_p6_wmul #(.A_WIDTH(G_WIDTH), .B_WIDTH(COEFW)) u_mul_gr (
            .aclk     (aclk),
            .stage_en (adv[11:10]),
            .a        (g_prod[i]),
            .b        (deriv_coeff_reg.mag),
            .p        (gr_prod[i])
        );
    end

    sph_p6_wmul #(.A_WIDTH(DT_WIDTH), .B_WIDTH(COEFW)) u_mul_lp (
        .aclk     (aclk),
        .stage_en (adv[11:10]),
        .a        (dt9_reg),
        .b        (deriv_coeff_reg.mag),
        .p        (lp_prod)
    );

    // -------------------------------- stages 12..14: sign, shift, saturate
    logic [RESULT_WIDTH-1:0] kv_res;
    logic [RESULT_WIDTH-1:0] grad_res [3];
    logic [RESULT_WIDTH-1:0] lap_res;
    logic                    rng12_reg;
    logic                    rng13_reg;
    logic                    rng14_reg;

    sph_p6_finish #(.MAG_WIDTH(KV_WIDTH), .RESULT_WIDTH(RESULT_WIDTH)) u_fin_kv (
        .aclk     (aclk),
        .stage_en (adv[14:12]),
        .mag      (kv_prod),
        .neg      (value_coeff_reg.neg),
        .live     (carry_reg[11].in_range),
        .shift    (result_shift_reg),
        .result   (kv_res)
    );

    for (genvar i = 0; i < 3; i++) begin : g_grad_fin
        sph_p6_finish #(.MAG_WIDTH(GR_WIDTH), .RESULT_WIDTH(RESULT_WIDTH)) u_fin_gr (
            .aclk     (aclk),
            .stage_en (adv[14:12]),
            .mag      (gr_prod[i]),
            .neg      (carry_reg[11].axis_neg[i] ^ deriv_coeff_reg.neg),
            .live     (carry_reg[11].in_range),
            .shift    (result_shift_reg),
            .result   (grad_res[i])
        );
    end

    sph_p6_finish #(.MAG_WIDTH(LP_WIDTH), .RESULT_WIDTH(RESULT_WIDTH)) u_fin_lp (
        .aclk     (aclk),
        .stage_en (adv[14:12]),
        .mag      (lp_prod),
        .neg      (carry_reg[11].lap_neg ^ deriv_coeff_reg.neg),
        .live     (carry_reg[11].in_range),
        .shift    (result_shift_reg),
        .result   (lap_res)
    );

    always_ff @(posedge aclk) begin
        if (adv[12]) begin
            rng12_reg <= carry_reg[11].in_range;
        end
        if (adv[13]) begin
            rng13_reg <= rng12_reg;
        end
        if (adv[14]) begin
            rng14_reg <= rng13_reg;
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[5*RESULT_WIDTH-1:0] = {lap_res, grad_res[2], grad_res[1], grad_res[0], kv_res};
    end

    assign m_tuser = rng14_reg;

    // ---------------------------------------------------------------- checks
    `SPH_P6_ASSERT_IMP(a_out_of_range_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)
    `SPH_P6_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    `SPH_P6_ASSERT_NEXT(a_accept_enters_stage, aclk, aresetn, s_tvalid && s_tready, valid_reg[1])

endmodule

/* test/sph_poly6_kernel_eval_core_checker.sv */
// ----------------------------------------------------------------------------
// sph_poly6_kernel_eval_core_checker
// Watches the displacement, result and register channels of the poly6 core.
// It keeps its own copy of the registers and computes the kernel value,
// gradient and laplacian of every accepted displacement word at full width.
// It then compares each result word, field by field, with the oldest
// prediction and hands the count of mismatches to the testbench top.
// ----------------------------------------------------------------------------
module sph_poly6_kernel_eval_core_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,    // dx, dy, dz
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,    // kernel_value, grad_x, grad_y, grad_z, lap_value
    input  logic         m_tuser,    // in_range
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         run_done,
    output int           mismatch_count,
    output int           results_due
);

    localparam int NUM_FIELDS = 6;

    // kernel_value, grad_x, grad_y, grad_z, lap_value, in_range from index 0 up
    typedef logic [NUM_FIELDS-1:0][31:0] kernel_fields_t;

    logic [31:0]    radius_sq;
    logic [31:0]    value_coeff;
    logic [31:0]    deriv_coeff;
    logic [5:0]     result_shift;
    kernel_fields_t kernel_results_due[$];
    int             result_number;
    string          field_name [NUM_FIELDS] = '{"kernel_value", "grad_x", "grad_y",
                                                "grad_z", "lap_value", "in_range"};

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at result word %0d: %s", result_number, msg);
    endtask

    // floor shift of the signed product, then clamp to 32 bits
    function automatic logic [31:0] shift_saturate(input logic [127:0] mag, input logic neg);
        logic signed [127:0] v;
        v = neg ? -mag : mag;
        v = v >>> result_shift;
        if (v > 128'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        if (v < -128'sh8000_0000)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic kernel_fields_t eval_poly6(input logic [47:0] word);
        kernel_fields_t f;
        logic [15:0]    coord [3];
        logic [16:0]    coord_mag [3];
        logic [35:0]    r2;
        logic [35:0]    d;
        logic [35:0]    lin;
        logic [35:0]    quad;
        logic [32:0]    value_mag;
        logic [32:0]    deriv_mag;
        logic           value_neg;
        logic           deriv_neg;
        logic           lap_neg;
        f  = '0;
        r2 = '0;
        for (int i = 0; i < 3; i++) begin
            coord[i]     = word[16*i +: 16];
            coord_mag[i] = coord[i][15] ? 17'(17'h1_0000 - 17'(coord[i])) : 17'(coord[i]);
            r2           = r2 + 36'(coord_mag[i]) * 36'(coord_mag[i]);
        end
        // on or outside the sphere every field stays zero
        if (r2 >= 36'(radius_sq))
            return f;
        d         = 36'(radius_sq) - r2;
        value_neg = value_coeff[31];
        value_mag = value_neg ? 33'(33'h1_0000_0000 - 33'(value_coeff)) : 33'(value_coeff);
        deriv_neg = deriv_coeff[31];
        deriv_mag = deriv_neg ? 33'(33'h1_0000_0000 - 33'(deriv_coeff)) : 33'(deriv_coeff);
        f[0] = shift_saturate(128'(value_mag) * 128'(d) * 128'(d) * 128'(d), value_neg);
        for (int i = 0; i < 3; i++)
            f[1+i] = shift_saturate(128'(deriv_mag) * 128'(d) * 128'(d) * 128'(coord_mag[i]),
                                    deriv_neg ^ coord[i][15]);
        lin     = d + d + d;
        quad    = r2 << 2;
        lap_neg = quad > lin;
        f[4] = shift_saturate(128'(deriv_mag) * 128'(d) * 128'(lap_neg ? quad - lin : lin - quad),
                              deriv_neg ^ lap_neg);
        f[5] = 32'd1;
        return f;
    endfunction

    always @(posedge aclk) begin
        kernel_fields_t want;
        kernel_fields_t got;
        if (!aresetn) begin
            radius_sq    = sph_p6_pkg::RADIUS_SQ_RESET;
            value_coeff  = '0;
            deriv_coeff  = '0;
            result_shift = '0;
            kernel_results_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {32'(m_tuser), m_tdata};
                result_number++;
                if (kernel_results_due.size() == 0) begin
                    report_mismatch("result word with no displacement waiting");
                end else begin
                    want = kernel_results_due.pop_front();
                    for (int i = 0; i < NUM_FIELDS; i++)
                        if (got[i] !== want[i])
                            report_mismatch($sformatf("%s is %h, expected %h",
                                                      field_name[i], got[i], want[i]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sph_p6_pkg::CFG_RADIUS_SQ:    radius_sq    = cfg_data;
                    sph_p6_pkg::CFG_VALUE_COEFF:  value_coeff  = cfg_data;
                    sph_p6_pkg::CFG_DERIV_COEFF:  deriv_coeff  = cfg_data;
                    sph_p6_pkg::CFG_RESULT_SHIFT: result_shift = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                kernel_results_due.push_back(eval_poly6(s_tdata));
        end
        results_due = kernel_results_due.size();
    end

    always @(posedge run_done) begin
        if (kernel_results_due.size() != 0)
            report_mismatch($sformatf("%0d result words never came",
                                      kernel_results_due.size()));
    end

endmodule

/* test/sph_poly6_kernel_eval_core_tb.sv */
// ----------------------------------------------------------------------------
// sph_poly6_kernel_eval_core_tb
// Drives displacement words and register writes into the poly6 core.
// Directed words cover reset settings, the sphere boundary, zero and full
// radius and both saturation limits. Random phases follow with mixes of
// sender gaps and result back-pressure. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module sph_poly6_kernel_eval_core_tb;

    localparam int COORD_WIDTH        = 16;
    localparam int RESULT_WIDTH       = 32;
    localparam int IN_BITS            = ((3*COORD_WIDTH+7)/8)*8;
    localparam int OUT_BITS           = ((5*RESULT_WIDTH+7)/8)*8;
    localparam int FIRST_UNUSED_INDEX = int'(sph_p6_pkg::CFG_RESULT_SHIFT) + 1;
    localparam int WORDS_PER_PHASE    = 138;
    localparam int NUM_CORNERS        = 6;
    localparam int DRAIN_LIMIT        = 5000;

    logic                                   aclk       = 1'b0;
    logic                                   aresetn    = 1'b0;
    logic                                   s_tvalid   = 1'b0;
    logic                                   s_tready;
    logic [IN_BITS-1:0]                     s_tdata    = '0;   // dx, dy, dz
    logic                                   m_tvalid;
    logic                                   m_tready   = 1'b0;
    logic [OUT_BITS-1:0]                    m_tdata;   // kernel_value, grad_x, grad_y,
                                                       // grad_z, lap_value
    logic                                   m_tuser;           // in_range
    logic                                   cfg_valid  = 1'b0;
    logic                                   cfg_ready;
    logic [sph_p6_pkg::CFG_INDEX_WIDTH-1:0] cfg_index  = '0;
    logic [sph_p6_pkg::CFG_DATA_WIDTH-1:0]  cfg_data   = '0;
    logic                                   run_done   = 1'b0;
    int                                     mismatch_count;
    int                                     results_due;
    int                                     sender_idle_pct    = 0;
    int                                     receiver_stall_pct = 0;
    int                                     words_sent         = 0;
    int                                     settings_used      = 1;

    // corner displacements: full positive, full negative, mixed, origin, tiny, lone axis
    logic [15:0] corner [NUM_CORNERS][3] = '{
        '{16'h7FFF, 16'h7FFF, 16'h7FFF},
        '{16'h8000, 16'h8000, 16'h8000},
        '{16'h8000, 16'h7FFF, 16'h0000},
        '{16'h0000, 16'h0000, 16'h0000},
        '{16'h0001, 16'hFFFF, 16'h0001},
        '{16'h0000, 16'h0000, 16'h8000}
    };

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sph_poly6_kernel_eval_core #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RESULT_WIDTH (RESULT_WIDTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sph_poly6_kernel_eval_core_checker i_kernel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .run_done       (run_done),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // called and returns at a falling edge
    task automatic send_displacement(input logic [15:0] x, input logic [15:0] y,
                                     input logic [15:0] z);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [31:0] radius, input logic [31:0] value,
                                input logic [31:0] deriv, input logic [5:0] shift);
        wait_results_drained();
        write_reg(sph_p6_pkg::CFG_RADIUS_SQ, radius);
        write_reg(sph_p6_pkg::CFG_VALUE_COEFF, value);
        write_reg(sph_p6_pkg::CFG_DERIV_COEFF, deriv);
        // junk above the shift field must be dropped
        write_reg(sph_p6_pkg::CFG_RESULT_SHIFT, ($urandom() & ~32'h3F) | 32'(shift));
        // an unmapped index must leave every register alone
        write_reg(8'($urandom_range(255, FIRST_UNUSED_INDEX)), $urandom());
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] rand_coord();
        logic [15:0] raw;
        raw = 16'($urandom());
        if ($urandom_range(3) == 0)
            return raw;
        return 16'($signed(raw) >>> $urandom_range(15, 1));
    endfunction

    function automatic logic [31:0] rand_coeff();
        return 32'($signed($urandom()) >>> $urandom_range(31, 0));
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: radius 1.0, coefficients zero; two words sit on the sphere
        send_displacement(16'h0000, 16'h0000, 16'h0000);
        send_displacement(16'h1000, 16'h0000, 16'h0000);
        send_displacement(16'hF000, 16'h0000, 16'h0000);
        send_displacement(16'h0800, 16'h0800, 16'h0800);

        // zero radius puts even the origin out of range
        program_regs(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0);
        send_displacement(16'h0000, 16'h0000, 16'h0000);
        send_displacement(16'h0001, 16'h0000, 16'h0000);

        // full radius with extreme coefficients, both shift extremes
        program_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0);
        for (int i = 0; i < NUM_CORNERS; i++)
            send_displacement(corner[i][0], corner[i][1], corner[i][2]);
        program_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 6'd63);
        for (int i = 0; i < NUM_CORNERS; i++)
            send_displacement(corner[i][0], corner[i][1], corner[i][2]);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    program_regs(32'h0400_0000, rand_coeff(), rand_coeff(), 6'd63);
                end
                1: begin
                    sender_idle_pct    = 72;
                    receiver_stall_pct = 0;
                    program_regs(32'hFFFF_FFFF, rand_coeff(), rand_coeff(),
                                 6'($urandom_range(63)));
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 72;
                    program_regs($urandom(), rand_coeff(), rand_coeff(), 6'd0);
                end
                default: begin
                    sender_idle_pct    = 22;
                    receiver_stall_pct = 22;
                    program_regs(sph_p6_pkg::RADIUS_SQ_RESET, rand_coeff(), rand_coeff(),
                                 6'd56);
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // hold off once until the pipeline has emptied
                if (ph == 3 && n == WORDS_PER_PHASE / 2)
                    wait_results_drained();
                send_displacement(rand_coord(), rand_coord(), rand_coord());
            end
        end

        s_tvalid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && results_due != 0; w++)
            @(negedge aclk);
        repeat (30) @(negedge aclk);
        run_done <= 1'b1;
        repeat (2) @(negedge aclk);

        $display("sent %0d displacement words under %0d register settings", words_sent,
                 settings_used);
        $display("zero and full radius, shifts 0 and 63, sender gaps and result stalls mixed");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #400000;
        $display("timeout: results still due %0d", results_due);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/sph_p6_pkg.sv
rtl/sph_p6_wmul.sv
rtl/sph_p6_finish.sv
rtl/sph_poly6_kernel_eval_core.sv
test/sph_poly6_kernel_eval_core_checker.sv
test/sph_poly6_kernel_eval_core_tb.sv
